// ===== rtl/tesm_pkg.sv =====
// Shared types and constants of the timed effect slot mixer.
package tesm_pkg;

   localparam int SLOTS  = 8;
   localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

   localparam int TIME_W  = 24;
   localparam int LVL_W   = 16;
   localparam int ID_W    = 16;
   localparam int TOTAL_W = 19;

   localparam logic [TIME_W-1:0]  MIN_DUR_RESET = TIME_W'(50000);
   localparam logic [TOTAL_W-1:0] TOTAL_MAX     = {TOTAL_W{1'b1}};

   // request codes; an unknown request is taken and dropped with no result
   localparam logic [1:0] REQ_TICK    = 2'd0;
   localparam logic [1:0] REQ_START   = 2'd1;
   localparam logic [1:0] REQ_QUERY   = 2'd2;
   localparam logic [1:0] REQ_UNKNOWN = 2'd3;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FINISH
   } tesm_state_type;

   typedef struct packed {
      logic [1:0]        req_type;
      logic [TIME_W-1:0] duration;
      logic [LVL_W-1:0]  heavy_level;
      logic [LVL_W-1:0]  light_level;
      logic [ID_W-1:0]   query_id;
      logic [LVL_W-1:0]  tick_delta;
   } tesm_req_type;

   typedef struct packed {
      logic               start_ok;
      logic [ID_W-1:0]    effect_id;
      logic               is_live;
      logic [TOTAL_W-1:0] heavy_total;
      logic [TOTAL_W-1:0] light_total;
   } tesm_rsp_type;

endpackage

// ===== rtl/timed_effect_slot_mixer.sv =====
// Top level of the timed effect slot mixer: slot table, scan sequencer, result register.
//
// Usage
//   req_* : valid/ready input channel, one beat per request (tick, start, query).
//   rsp_* : valid/ready result channel, one beat per tick, start or query.
//           A request of type 3 is taken and dropped with no result beat.
//   csr_* : write enable and data for min_duration; write only while idle.
// Sequencing
//   A request is taken only while the sequencer is idle. It then walks the slot
//   table one slot per cycle through one shared time compare/subtract unit and
//   one pair of saturating adders: a tick visits every slot, a start or query
//   stops at the first hit (or the last slot); the finish step then loads the
//   result register, and only then is the next request taken.
// Stalls
//   The result register holds a finished beat while rsp_ready is low, and the
//   next request is still taken and scanned; a second result then waits in
//   the finish step until the register frees.
// Reset
//   Synchronous, active high: slot times and tags clear to zero, id counter to
//   zero, min_duration to 50000, sequencer idle, no result pending.
module timed_effect_slot_mixer
   import tesm_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  tesm_req_type      req_payload,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output tesm_rsp_type      rsp_payload,
   input  logic              csr_wr_en,
   input  logic [TIME_W-1:0] csr_wr_data
);

   // slot table
   logic [TIME_W-1:0] slot_time_ff  [SLOTS];
   logic [ID_W-1:0]   slot_tag_ff   [SLOTS];
   logic [LVL_W-1:0]  slot_heavy_ff [SLOTS];
   logic [LVL_W-1:0]  slot_light_ff [SLOTS];

   logic [TIME_W-1:0] min_dur_ff;
   logic [ID_W-1:0]   id_counter_ff;

   // sequencer and the latched request
   tesm_state_type    state_ff, state_in;
   logic [SLOT_W-1:0] idx_ff;
   logic [1:0]        op_ff;
   logic [TIME_W-1:0] dur_ff;
   logic [LVL_W-1:0]  heavy_ff, light_ff;
   logic [ID_W-1:0]   qid_ff;
   logic [LVL_W-1:0]  delta_ff;

   // running results
   logic [TOTAL_W-1:0] hsum_ff, lsum_ff;
   logic               ok_ff, live_ff;

   logic         rsp_valid_ff;
   tesm_rsp_type rsp_ff, rsp_in;

   logic req_fire, scan_en, fin_load, out_free;
   logic last, hit, scan_done;

   logic [TIME_W-1:0]  cur_time, time_sub, dur_raised;
   logic               cur_live;
   logic [TOTAL_W:0]   hadd, ladd;

   assign req_fire = req_valid && req_ready;
   assign out_free = !rsp_valid_ff || rsp_ready;

   assign cur_time = slot_time_ff[idx_ff];
   assign cur_live = (cur_time != '0);
   assign last     = (idx_ff == SLOT_W'(SLOTS - 1));

   // shared unit: saturating time decrement for ticks
   assign time_sub = (cur_time > TIME_W'(delta_ff)) ? (cur_time - TIME_W'(delta_ff)) : '0;

   assign hadd = {1'b0, hsum_ff} + (TOTAL_W + 1)'(slot_heavy_ff[idx_ff]);
   assign ladd = {1'b0, lsum_ff} + (TOTAL_W + 1)'(slot_light_ff[idx_ff]);

   always_comb begin
      unique case (op_ff)
         REQ_START: hit = !cur_live;
         REQ_QUERY: hit = (slot_tag_ff[idx_ff] == qid_ff);
         default:   hit = 1'b0;
      endcase
   end

   assign scan_done  = hit || last;
   assign dur_raised = (req_payload.duration < min_dur_ff) ? min_dur_ff
                                                             : req_payload.duration;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire && req_payload.req_type != REQ_UNKNOWN) state_in = ST_SCAN;
         end
         ST_SCAN: begin
            if (scan_done) state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // sequencer outputs
   always_comb begin
      req_ready = 1'b0;
      scan_en   = 1'b0;
      fin_load  = 1'b0;
      unique case (state_ff)
         ST_IDLE:   req_ready = 1'b1;
         ST_SCAN:   scan_en   = 1'b1;
         ST_FINISH: fin_load  = out_free;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         min_dur_ff <= MIN_DUR_RESET;
      end else if (csr_wr_en) begin
         min_dur_ff <= csr_wr_data;
      end
   end

   // id counter bumps on every start, also a failing one
   always_ff @(posedge clock) begin
      if (reset) begin
         id_counter_ff <= '0;
      end else if (req_fire && req_payload.req_type == REQ_START) begin
         id_counter_ff <= id_counter_ff + ID_W'(1);
      end
   end

   // latch request; the block below clears the running results on the same accept
   always_ff @(posedge clock) begin
      if (req_fire) begin
         op_ff    <= req_payload.req_type;
         dur_ff   <= dur_raised;
         heavy_ff <= req_payload.heavy_level;
         light_ff <= req_payload.light_level;
         qid_ff   <= req_payload.query_id;
         delta_ff <= req_payload.tick_delta;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff  <= '0;
         hsum_ff <= '0;
         lsum_ff <= '0;
         ok_ff   <= 1'b0;
         live_ff <= 1'b0;
      end else if (req_fire) begin
         idx_ff  <= '0;
         hsum_ff <= '0;
         lsum_ff <= '0;
         ok_ff   <= 1'b0;
         live_ff <= 1'b0;
      end else if (scan_en) begin
         if (!last) idx_ff <= idx_ff + SLOT_W'(1);
         unique case (op_ff)
            REQ_TICK: begin
               if (cur_live) begin
                  hsum_ff <= hadd[TOTAL_W] ? TOTAL_MAX : hadd[TOTAL_W-1:0];
                  lsum_ff <= ladd[TOTAL_W] ? TOTAL_MAX : ladd[TOTAL_W-1:0];
               end
            end
            REQ_START: begin
               if (hit) ok_ff <= 1'b1;
            end
            REQ_QUERY: begin
               if (hit) live_ff <= cur_live;
            end
            default: ;
         endcase
      end
   end

   // slot table writes at the scan index
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < SLOTS; i++) begin
            slot_time_ff[i] <= '0;
            slot_tag_ff[i]  <= '0;
         end
      end else if (scan_en) begin
         if (op_ff == REQ_TICK) begin
            slot_time_ff[idx_ff] <= time_sub;
         end else if (op_ff == REQ_START && hit) begin
            slot_time_ff[idx_ff] <= dur_ff;
            slot_tag_ff[idx_ff]  <= id_counter_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (scan_en && op_ff == REQ_START && hit) begin
         slot_heavy_ff[idx_ff] <= heavy_ff;
         slot_light_ff[idx_ff] <= light_ff;
      end
   end

   // result beat; fields that do not apply stay zero
   always_comb begin
      rsp_in             = '0;
      rsp_in.start_ok    = ok_ff;
      rsp_in.effect_id   = ok_ff ? id_counter_ff : '0;
      rsp_in.is_live     = live_ff;
      rsp_in.heavy_total = hsum_ff;
      rsp_in.light_total = lsum_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (fin_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (fin_load) rsp_ff <= rsp_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   // checks
   a_id_bump: assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_payload.req_type == REQ_START)
      |=> id_counter_ff == $past(id_counter_ff) + ID_W'(1))
      else $error("id counter did not advance on start");

   a_fail_id_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_payload.start_ok) |-> rsp_payload.effect_id == '0)
      else $error("failed start carries an id");

   a_drop_unknown: assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_payload.req_type == REQ_UNKNOWN) |=> state_ff == ST_IDLE)
      else $error("unknown request started a scan");

   a_finish_loads: assert property (@(posedge clock) disable iff (reset)
      fin_load |=> (rsp_valid_ff && state_ff == ST_IDLE))
      else $error("finished result not presented");

   a_tick_full_scan: assert property (@(posedge clock) disable iff (reset)
      (scan_en && op_ff == REQ_TICK && !last) |=> state_ff == ST_SCAN)
      else $error("tick scan ended early");

endmodule

// ===== verif/tb.sv =====
// Testbench for the timed effect slot mixer: directed and random beats, predicted and checked.
module tb;
   import tesm_pkg::*;

   // Expected-beat store and slot table predictor. It mirrors the block's table,
   // id counter and minimum duration, and predicts one result beat per tick, start or query.
   class effect_table_board;
      logic [TIME_W-1:0] time_left [SLOTS];
      logic [LVL_W-1:0]  heavy     [SLOTS];
      logic [LVL_W-1:0]  light     [SLOTS];
      logic [ID_W-1:0]   tag       [SLOTS];
      logic [ID_W-1:0]   id_count;
      logic [TIME_W-1:0] min_dur;
      tesm_rsp_type      due_rsps [$];
      int                fails;

      function new();
         foreach (time_left[i]) begin
            time_left[i] = '0;
            heavy[i]     = '0;
            light[i]     = '0;
            tag[i]       = '0;
         end
         id_count = '0;
         min_dur  = MIN_DUR_RESET;
         fails    = 0;
      endfunction

      function void set_min_duration(logic [TIME_W-1:0] value);
         min_dur = value;
      endfunction

      // Advance the table by one accepted request beat and queue its result; a type 3 beat queues none.
      function void apply_request(tesm_req_type r);
         tesm_rsp_type      e;
         int unsigned       hsum;
         int unsigned       lsum;
         logic [TIME_W-1:0] dur;
         int                hit;
         e    = '0;
         hsum = 0;
         lsum = 0;
         hit  = -1;
         case (r.req_type)
            REQ_TICK: begin
               foreach (time_left[i]) begin
                  if (time_left[i] != '0) begin
                     hsum += 32'(heavy[i]);
                     lsum += 32'(light[i]);
                     if (hsum > 32'(TOTAL_MAX)) hsum = 32'(TOTAL_MAX);
                     if (lsum > 32'(TOTAL_MAX)) lsum = 32'(TOTAL_MAX);
                  end
                  time_left[i] = (time_left[i] > TIME_W'(r.tick_delta)) ?
                                 time_left[i] - TIME_W'(r.tick_delta) : '0;
               end
               e.heavy_total = hsum[TOTAL_W-1:0];
               e.light_total = lsum[TOTAL_W-1:0];
            end
            REQ_START: begin
               id_count++;
               dur = (r.duration < min_dur) ? min_dur : r.duration;
               foreach (time_left[i])
                  if (hit < 0 && time_left[i] == '0) hit = i;
               if (hit >= 0) begin
                  time_left[hit] = dur;
                  heavy[hit]     = r.heavy_level;
                  light[hit]     = r.light_level;
                  tag[hit]       = id_count;
                  e.start_ok     = 1'b1;
                  e.effect_id    = id_count;
               end
            end
            REQ_QUERY: begin
               foreach (tag[i])
                  if (hit < 0 && tag[i] == r.query_id) hit = i;
               if (hit >= 0) e.is_live = (time_left[hit] != '0);
            end
            default: return;
         endcase
         due_rsps.push_back(e);
      endfunction

      function void check_rsp(tesm_rsp_type got);
         tesm_rsp_type e;
         if (due_rsps.size() == 0) begin
            $error("result beat with nothing expected: %h", got);
            fails++;
            return;
         end
         e = due_rsps.pop_front();
         if (got.start_ok !== e.start_ok) begin
            $error("start_ok mismatch: expected %0d, got %0d", e.start_ok, got.start_ok);
            fails++;
         end
         if (got.effect_id !== e.effect_id) begin
            $error("effect_id mismatch: expected %0d, got %0d", e.effect_id, got.effect_id);
            fails++;
         end
         if (got.is_live !== e.is_live) begin
            $error("is_live mismatch: expected %0d, got %0d", e.is_live, got.is_live);
            fails++;
         end
         if (got.heavy_total !== e.heavy_total) begin
            $error("heavy_total mismatch: expected %0d, got %0d",
                   e.heavy_total, got.heavy_total);
            fails++;
         end
         if (got.light_total !== e.light_total) begin
            $error("light_total mismatch: expected %0d, got %0d",
                   e.light_total, got.light_total);
            fails++;
         end
      endfunction
   endclass

   logic              clock       = 1'b0;
   logic              reset       = 1'b1;
   logic              req_valid   = 1'b0;
   logic              req_ready;
   tesm_req_type      req_payload = '0;
   logic              rsp_valid;
   logic              rsp_ready   = 1'b0;
   tesm_rsp_type      rsp_payload;
   logic              csr_wr_en   = 1'b0;
   logic [TIME_W-1:0] csr_wr_data = '0;

   // Idle percentages of the current phase: sender gaps and receiver stalls.
   int                req_gap_pct   = 0;
   int                rsp_stall_pct = 0;

   effect_table_board board;

   timed_effect_slot_mixer DUT (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always #4 clock = ~clock;

   // Receiver: checks every accepted result beat against the oldest prediction,
   // then picks next cycle's ready. Values read here are the ones at the edge,
   // as every input of the block changes only through nonblocking updates.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) board.check_rsp(rsp_payload);
      rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
   end

   // Hard stop in case the block hangs; sized well above the slowest good run.
   initial begin
      #1000000;
      $display("Verification failed");
      $finish;
   end

   // Offers one request beat and returns at the edge that takes it. Valid is
   // only lowered for a sender gap, so a back-to-back beat keeps valid high
   // and never sees two updates in one step.
   task automatic send_req(input tesm_req_type r);
      if ($urandom_range(99) < req_gap_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < req_gap_pct);
      end
      req_valid   <= 1'b1;
      req_payload <= r;
      do @(posedge clock); while (!req_ready);
      board.apply_request(r);
   endtask

   task automatic send_fields(input logic [1:0] kind, input logic [TIME_W-1:0] dur,
                              input logic [LVL_W-1:0] hv, input logic [LVL_W-1:0] lt,
                              input logic [ID_W-1:0] qid, input logic [LVL_W-1:0] delta);
      tesm_req_type r;
      r.req_type    = kind;
      r.duration    = dur;
      r.heavy_level = hv;
      r.light_level = lt;
      r.query_id    = qid;
      r.tick_delta  = delta;
      send_req(r);
   endtask

   // Waits for every predicted beat, then lets a dropped type 3 request or a
   // trailing scan run out before anything else happens.
   task automatic drain();
      req_valid <= 1'b0;
      while (board.due_rsps.size() != 0) @(posedge clock);
      repeat (SLOTS + 6) @(posedge clock);
   endtask

   task automatic write_min_duration(input logic [TIME_W-1:0] value);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      board.set_min_duration(value);
   endtask

   // Random beats for one phase: mostly starts, ticks and queries of recent ids
   // so that slots fill, age and expire; a few dropped type 3 beats as noise.
   task automatic run_random(input int beats);
      tesm_req_type r;
      int           n;
      int           pick;
      n = 0;
      while (n < beats) begin
         pick          = $urandom_range(99);
         r.req_type    = (pick < 35) ? REQ_TICK : (pick < 70) ? REQ_START :
                         (pick < 95) ? REQ_QUERY : REQ_UNKNOWN;
         r.duration    = TIME_W'($urandom);
         r.heavy_level = LVL_W'($urandom);
         r.light_level = LVL_W'($urandom);
         r.query_id    = ID_W'($urandom);
         r.tick_delta  = LVL_W'($urandom);
         pick          = $urandom_range(99);
         case (r.req_type)
            REQ_START: begin
               // short lives dominate so the table keeps turning over
               if (pick < 45)      r.duration = TIME_W'($urandom_range(0, 150000));
               else if (pick < 70) r.duration = TIME_W'($urandom_range(0, 100));
               else if (pick < 85) r.duration = board.min_dur ^
                                                TIME_W'($urandom_range(0, 3));
            end
            REQ_TICK: begin
               if (pick < 50) r.tick_delta = LVL_W'($urandom_range(0, 4000));
            end
            REQ_QUERY: begin
               if (pick < 60)      r.query_id = board.id_count -
                                                ID_W'($urandom_range(0, 10));
               else if (pick < 75) r.query_id = '0;
            end
            default: ;
         endcase
         send_req(r);
         if (r.req_type != REQ_UNKNOWN) n++;
      end
   endtask

   initial begin
      logic [TIME_W-1:0] phase_min [5];
      int                gap_pct   [5];
      int                stall_pct [5];
      board = new();
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Directed beats at the reset minimum of 50000 us.
      // Query of id 0 hits the never-used slot 0: tag matches, not live.
      send_fields(REQ_QUERY, 24'd0, 16'd0, 16'd0, 16'h0000, 16'd0);
      send_fields(REQ_TICK, 24'd0, 16'd0, 16'd0, 16'd0, 16'h0000);
      // Zero duration raised to the minimum; extreme levels.
      send_fields(REQ_START, 24'h000000, 16'hFFFF, 16'h0000, 16'd0, 16'd0);
      send_fields(REQ_START, 24'hFFFFFF, 16'h0000, 16'hFFFF, 16'd0, 16'd0);
      // Fill the rest of the table, then a start with no free slot.
      repeat (SLOTS - 2)
         send_fields(REQ_START, 24'd100000, 16'hFFFF, 16'hFFFF, 16'd0, 16'd0);
      send_fields(REQ_START, 24'd5, 16'h1234, 16'h4321, 16'd0, 16'd0);
      send_fields(REQ_TICK, 24'd0, 16'd0, 16'd0, 16'd0, 16'h0000);
      send_fields(REQ_QUERY, 24'd0, 16'd0, 16'd0, 16'd2, 16'd0);
      // Id of the failed start is never stored: a query miss.
      send_fields(REQ_QUERY, 24'd0, 16'd0, 16'd0, 16'd9, 16'd0);
      // Largest delta: slot 0 expires, its tag stays behind.
      send_fields(REQ_TICK, 24'd0, 16'd0, 16'd0, 16'd0, 16'hFFFF);
      send_fields(REQ_QUERY, 24'd0, 16'd0, 16'd0, 16'd1, 16'd0);
      send_req('1);
      send_fields(REQ_TICK, 24'd0, 16'd0, 16'd0, 16'd0, 16'hFFFF);
      send_fields(REQ_QUERY, 24'd0, 16'd0, 16'd0, 16'd3, 16'd0);
      drain();

      // Zero minimum: a zero-length start succeeds yet leaves its slot free.
      write_min_duration('0);
      send_fields(REQ_START, 24'd0, 16'hA5A5, 16'h5A5A, 16'd0, 16'd0);
      send_fields(REQ_QUERY, 24'd0, 16'd0, 16'd0, board.id_count, 16'd0);
      send_fields(REQ_START, 24'd1, 16'h8001, 16'h7FFE, 16'd0, 16'd0);
      send_fields(REQ_TICK, 24'd0, 16'd0, 16'd0, 16'd0, 16'd1);

      // A few zero-length starts reuse the same free slot, then look up id 0,
      // which no slot carries any more.
      repeat (4)
         send_fields(REQ_START, 24'd0, LVL_W'($urandom), LVL_W'($urandom), 16'd0, 16'd0);
      send_fields(REQ_QUERY, 24'd0, 16'd0, 16'd0, 16'h0000, 16'd0);
      send_fields(REQ_TICK, 24'd0, 16'd0, 16'd0, 16'd0, 16'd0);
      drain();

      // Random phases: each with its own minimum and an idling mix; the largest
      // minimum comes last as it clogs the table for hundreds of ticks.
      phase_min = '{MIN_DUR_RESET, 24'd0, 24'($urandom),
                    24'($urandom_range(0, 2000)), 24'hFFFFFF};
      gap_pct   = '{0, 45, 0, 38, 38};
      stall_pct = '{0, 0, 45, 38, 38};
      for (int p = 0; p < 5; p++) begin
         write_min_duration(phase_min[p]);
         req_gap_pct   = gap_pct[p];
         rsp_stall_pct = stall_pct[p];
         run_random(80);
         drain();
      end

      if (board.fails == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/tesm_pkg.sv
rtl/timed_effect_slot_mixer.sv
verif/tb.sv
